FILE: sv/p1305_pkg.sv
// Shared constants, types and the multiply schedule for the Poly1305 MAC unit.
// Used by p1305_mul, p1305_add and poly1305_mac_unit.
package p1305_pkg;

    localparam int ACC_W   = 130;   // accumulator, kept below 2^130
    localparam int BLK_W   = 129;   // padded message block
    localparam int X_W     = 132;   // work register and adder width
    localparam int PROD_W  = 259;   // full product before folding
    localparam int COL_W   = 67;    // column accumulator
    localparam int TIN_W   = 136;   // input tdata, padded to bytes
    localparam int TOUT_W  = 128;

    localparam int MUL_STEPS = 20;  // 5 words of a times 4 words of r
    localparam logic [4:0] MUL_LAST = 5'(MUL_STEPS - 1);

    localparam logic [127:0] R_CLAMP = 128'h0ffffffc0ffffffc0ffffffc0fffffff;
    localparam logic [X_W-1:0] ADD_FIVE = X_W'(5);

    localparam logic [1:0] CFG_R_LO = 2'd0;
    localparam logic [1:0] CFG_R_HI = 2'd1;
    localparam logic [1:0] CFG_S_LO = 2'd2;
    localparam logic [1:0] CFG_S_HI = 2'd3;

    typedef enum logic [2:0] {
        OP_ADD_BLK,
        OP_FOLD_LH,
        OP_FOLD_H4,
        OP_FOLD_TOP,
        OP_PLUS5,
        OP_ADD_S
    } t_add_op;

    typedef struct packed {
        logic [2:0] ai;     // word of acc + block
        logic [1:0] bi;     // word of clamped r
        logic       eoc;    // last product of its column
    } t_step;

    // Product-scanning order: columns k = ai + bi from 0 to 7.
    function automatic t_step step_info(input logic [4:0] idx);
        t_step st;
        st = '{ai: 3'd0, bi: 2'd0, eoc: 1'b0};
        case (idx)
            5'd0:  st = '{ai: 3'd0, bi: 2'd0, eoc: 1'b1};
            5'd1:  st = '{ai: 3'd0, bi: 2'd1, eoc: 1'b0};
            5'd2:  st = '{ai: 3'd1, bi: 2'd0, eoc: 1'b1};
            5'd3:  st = '{ai: 3'd0, bi: 2'd2, eoc: 1'b0};
            5'd4:  st = '{ai: 3'd1, bi: 2'd1, eoc: 1'b0};
            5'd5:  st = '{ai: 3'd2, bi: 2'd0, eoc: 1'b1};
            5'd6:  st = '{ai: 3'd0, bi: 2'd3, eoc: 1'b0};
            5'd7:  st = '{ai: 3'd1, bi: 2'd2, eoc: 1'b0};
            5'd8:  st = '{ai: 3'd2, bi: 2'd1, eoc: 1'b0};
            5'd9:  st = '{ai: 3'd3, bi: 2'd0, eoc: 1'b1};
            5'd10: st = '{ai: 3'd1, bi: 2'd3, eoc: 1'b0};
            5'd11: st = '{ai: 3'd2, bi: 2'd2, eoc: 1'b0};
            5'd12: st = '{ai: 3'd3, bi: 2'd1, eoc: 1'b0};
            5'd13: st = '{ai: 3'd4, bi: 2'd0, eoc: 1'b1};
            5'd14: st = '{ai: 3'd2, bi: 2'd3, eoc: 1'b0};
            5'd15: st = '{ai: 3'd3, bi: 2'd2, eoc: 1'b0};
            5'd16: st = '{ai: 3'd4, bi: 2'd1, eoc: 1'b1};
            5'd17: st = '{ai: 3'd3, bi: 2'd3, eoc: 1'b0};
            5'd18: st = '{ai: 3'd4, bi: 2'd2, eoc: 1'b1};
            5'd19: st = '{ai: 3'd4, bi: 2'd3, eoc: 1'b1};
            default: st = '{ai: 3'd0, bi: 2'd0, eoc: 1'b0};
        endcase
        return st;
    endfunction

endpackage

FILE: sv/p1305_mul.sv
// Shared 32x32 multiplier with registered product.
// Depends on p1305_pkg.
module p1305_mul
    import p1305_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_a * i_b;
        end
    end

    assign o_p = r_p;

endmodule

FILE: sv/p1305_add.sv
// Shared 132-bit adder with operand selection for block add, modular folds,
// final reduction and the s addition. Depends on p1305_pkg.
module p1305_add
    import p1305_pkg::*;
(
    input  t_add_op           i_op,
    input  logic [ACC_W-1:0]  i_acc,
    input  logic [BLK_W-1:0]  i_blk,
    input  logic [PROD_W-1:0] i_prod,
    input  logic [X_W-1:0]    i_x,
    input  logic [127:0]      i_tsel,
    input  logic [127:0]      i_s,
    output logic [X_W-1:0]    o_sum
);

    logic [X_W-1:0] w_a;
    logic [X_W-1:0] w_b;
    logic [4:0]     w_top5;

    // 5 * top bits, for folding 2^130 = 5 mod p
    assign w_top5 = {1'b0, i_x[131:130], 2'b00} + {3'b000, i_x[131:130]};

    always_comb begin
        case (i_op)
            OP_ADD_BLK: begin
                w_a = {2'b00, i_acc};
                w_b = {3'b000, i_blk};
            end
            OP_FOLD_LH: begin
                w_a = {2'b00, i_prod[129:0]};
                w_b = {3'b000, i_prod[258:130]};
            end
            OP_FOLD_H4: begin
                w_a = i_x;
                w_b = {1'b0, i_prod[258:130], 2'b00};
            end
            OP_FOLD_TOP: begin
                w_a = {2'b00, i_x[129:0]};
                w_b = {127'd0, w_top5};
            end
            OP_PLUS5: begin
                w_a = {2'b00, i_acc};
                w_b = ADD_FIVE;
            end
            OP_ADD_S: begin
                w_a = {4'h0, i_tsel};
                w_b = {4'h0, i_s};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign o_sum = w_a + w_b;

endmodule

FILE: sv/poly1305_mac_unit.sv
// Poly1305 authenticator, one 16-byte message block per request. A block with a
// nonzero byte count passes through ADDB, which adds the block to the
// accumulator, then MUL, where the 20 partial products of (acc + block) * r
// run through one 32x32 multiplier, then a drain state. FLH, FH4 and FTOP
// passes of the shared 132-bit adder then fold the product mod 2^130-5, FTOP
// repeating until nothing is left above bit 129. Input is not ready during
// that time. A last block then goes through the final reduction and the s
// addition, waiting there while the previous tag still waits. A zero-count
// last block goes straight to the final reduction; a zero-count other block
// is taken without leaving idle. The tag sits in an output register while the
// next block is taken. The user must write keys through the config port only
// while idle; the block does not check. Uses p1305_pkg, p1305_mul, p1305_add.
module poly1305_mac_unit
    import p1305_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // config write port
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [63:0]       i_cfg_data,
    // block requests
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [63:0] block_low, [127:64] block_high, [132:128] block_bytes, rest zero
    input  logic [TIN_W-1:0]  i_s_axis_tdata,
    input  logic              i_s_axis_tlast,   // last_block
    // tag results
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // [63:0] tag_low, [127:64] tag_high
    output logic [TOUT_W-1:0] o_m_axis_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADDB,
        ST_MUL,
        ST_DRAIN,
        ST_FLH,
        ST_FH4,
        ST_FTOP,
        ST_G5,
        ST_TAG
    } t_state;

    t_state             r_state;
    logic [4:0]         r_step;
    logic               r_mv;
    logic               r_meoc;
    logic [COL_W-1:0]   r_col;
    logic [255:0]       r_prod;
    logic [X_W-1:0]     r_x;
    logic [ACC_W-1:0]   r_acc;
    logic [BLK_W-1:0]   r_blk;
    logic               r_last;
    logic [127:0]       r_tsel;
    logic [127:0]       r_tag;
    logic               r_ovalid;
    logic [63:0]        r_rk_lo;
    logic [63:0]        r_rk_hi;
    logic [63:0]        r_sk_lo;
    logic [63:0]        r_sk_hi;

    logic [4:0]         w_nb;
    logic [BLK_W-1:0]   w_pad;
    t_step              w_step;
    t_add_op            w_op;
    logic [X_W-1:0]     w_sum;
    logic [63:0]        w_mp;
    logic [COL_W-1:0]   w_col_sum;
    logic [127:0]       w_r;
    logic [159:0]       w_a;
    logic [31:0]        w_mul_a;
    logic [31:0]        w_mul_b;
    logic               w_mul_en;

    // byte count saturates at 16; pad byte 0x01 goes just above the data
    assign w_nb = (i_s_axis_tdata[132:128] > 5'd16) ? 5'd16 : i_s_axis_tdata[132:128];

    always_comb begin
        w_pad = '0;
        for (int k = 0; k < 16; k++) begin
            if (5'(k) < w_nb) begin
                w_pad[8*k +: 8] = i_s_axis_tdata[8*k +: 8];
            end
        end
        for (int k = 0; k <= 16; k++) begin
            if (w_nb == 5'(k)) begin
                w_pad[8*k] = 1'b1;
            end
        end
    end

    assign w_r      = {r_rk_hi, r_rk_lo} & R_CLAMP;
    assign w_a      = {29'd0, r_x[130:0]};
    assign w_step   = step_info(r_step);
    assign w_mul_a  = w_a[{w_step.ai, 5'd0} +: 32];
    assign w_mul_b  = w_r[{w_step.bi, 5'd0} +: 32];
    assign w_mul_en = (r_state == ST_MUL);

    assign w_col_sum = r_col + {3'b000, w_mp};

    always_comb begin
        case (r_state)
            ST_ADDB: w_op = OP_ADD_BLK;
            ST_FLH:  w_op = OP_FOLD_LH;
            ST_FH4:  w_op = OP_FOLD_H4;
            ST_FTOP: w_op = OP_FOLD_TOP;
            ST_G5:   w_op = OP_PLUS5;
            ST_TAG:  w_op = OP_ADD_S;
            default: w_op = OP_ADD_BLK;
        endcase
    end

    p1305_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_mul_en),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mp)
    );

    p1305_add u_add (
        .i_op   (w_op),
        .i_acc  (r_acc),
        .i_blk  (r_blk),
        .i_prod ({r_col[2:0], r_prod}),
        .i_x    (r_x),
        .i_tsel (r_tsel),
        .i_s    ({r_sk_hi, r_sk_lo}),
        .o_sum  (w_sum)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_step   <= '0;
            r_mv     <= 1'b0;
            r_meoc   <= 1'b0;
            r_ovalid <= 1'b0;
            r_acc    <= '0;
            r_rk_lo  <= '0;
            r_rk_hi  <= '0;
            r_sk_lo  <= '0;
            r_sk_hi  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_R_LO: r_rk_lo <= i_cfg_data;
                    CFG_R_HI: r_rk_hi <= i_cfg_data;
                    CFG_S_LO: r_sk_lo <= i_cfg_data;
                    CFG_S_HI: r_sk_hi <= i_cfg_data;
                    default:  r_rk_lo <= r_rk_lo;
                endcase
            end

            // a new tag may load in the same cycle the old one leaves
            if (r_state == ST_TAG && (!r_ovalid || i_m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            // product column accumulate, in the cycle after the multiplier step
            r_mv   <= w_mul_en;
            r_meoc <= w_step.eoc;
            if (r_mv) begin
                if (r_meoc) begin
                    r_prod <= {w_col_sum[31:0], r_prod[255:32]};
                    r_col  <= {32'd0, w_col_sum[COL_W-1:32]};
                end else begin
                    r_col <= w_col_sum;
                end
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_blk  <= w_pad;
                        r_last <= i_s_axis_tlast;
                        if (w_nb != 5'd0) begin
                            r_state <= ST_ADDB;
                        end else if (i_s_axis_tlast) begin
                            r_state <= ST_G5;
                        end
                    end
                end
                ST_ADDB: begin
                    r_x     <= w_sum;
                    r_col   <= '0;
                    r_step  <= '0;
                    r_state <= ST_MUL;
                end
                ST_MUL: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == MUL_LAST) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_FLH;
                end
                ST_FLH: begin
                    r_x     <= w_sum;
                    r_state <= ST_FH4;
                end
                ST_FH4: begin
                    r_x     <= w_sum;
                    r_state <= ST_FTOP;
                end
                ST_FTOP: begin
                    // repeat until nothing sits above bit 129
                    if (r_x[131:130] != 2'b00) begin
                        r_x <= w_sum;
                    end else begin
                        r_acc   <= r_x[129:0];
                        r_state <= r_last ? ST_G5 : ST_IDLE;
                    end
                end
                ST_G5: begin
                    // acc + 5 reaching 2^130 means acc >= p
                    r_tsel  <= w_sum[130] ? w_sum[127:0] : r_acc[127:0];
                    r_state <= ST_TAG;
                end
                ST_TAG: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_tag    <= w_sum[127:0];
                        r_acc    <= '0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_tag;

endmodule
